/* sv/rtc_cal_pkg.sv */
// Shared types, codes and calendar helper functions for the RTC calendar block.
package rtc_cal_pkg;

    localparam int unsigned DAY_SECONDS = 86400;
    localparam int unsigned SOD_W       = 17;
    localparam int unsigned ALARM_W     = 18;
    localparam int unsigned IN_W        = 40;
    localparam int unsigned OUT_W       = 40;
    localparam int unsigned LAST_YEAR   = 99;

    typedef enum logic [2:0] {
        MODE_TICK      = 3'd0,
        MODE_SET_TIME  = 3'd1,
        MODE_SET_DATE  = 3'd2,
        MODE_SET_ALARM = 3'd3,
        MODE_READ      = 3'd4
    } mode_t;

    typedef struct packed {
        logic [4:0] hours;
        logic [5:0] minutes;
        logic [5:0] seconds;
        logic       hit;
        logic       armed;
    } rtc_cal_time_t;

    typedef struct packed {
        logic [6:0] year;
        logic [3:0] month;
        logic [4:0] day;
        logic [2:0] weekday;
    } rtc_cal_date_t;

    // h*3600 + m*60 + s, taken as given; fits 17 bits for any field pattern
    function automatic logic [SOD_W-1:0] hms_count(
        input logic [4:0] h,
        input logic [5:0] m,
        input logic [5:0] s
    );
        hms_count = SOD_W'(h) * SOD_W'(3600) + SOD_W'(m) * SOD_W'(60) + SOD_W'(s);
    endfunction

    // Years 2000..2099: every fourth year is a leap year (2000 divides by 400)
    function automatic logic [4:0] month_len(
        input logic [6:0] yoff,
        input logic [3:0] m
    );
        logic leap;
        leap = (yoff[1:0] == 2'b00);
        case (m)
            4'd2:                         month_len = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:      month_len = 5'd30;
            default:                      month_len = 5'd31;
        endcase
    endfunction

    // (23 * m) / 9 for months 1..12
    function automatic logic [4:0] month_term(input logic [3:0] m);
        case (m)
            4'd1:    month_term = 5'd2;
            4'd2:    month_term = 5'd5;
            4'd3:    month_term = 5'd7;
            4'd4:    month_term = 5'd10;
            4'd5:    month_term = 5'd12;
            4'd6:    month_term = 5'd15;
            4'd7:    month_term = 5'd17;
            4'd8:    month_term = 5'd20;
            4'd9:    month_term = 5'd23;
            4'd10:   month_term = 5'd25;
            4'd11:   month_term = 5'd28;
            4'd12:   month_term = 5'd30;
            default: month_term = 5'd0;
        endcase
    endfunction

    // x mod 7 for x < 256: reciprocal estimate, then one correction
    function automatic logic [2:0] mod7(input logic [7:0] x);
        logic [15:0] prod;
        logic [7:0]  q;
        logic [7:0]  r;
        prod = 16'(x) * 16'd73;
        q    = 8'(prod >> 9);
        r    = x - 8'(q * 8'd7);
        if (r >= 8'd7)
            r = r - 8'd7;
        mod7 = r[2:0];
    endfunction

    // Weekday, 0 Sunday, for a valid date in 2000..2099. The year part of the
    // formula reduces mod 7 to yoff + leap count plus a small constant.
    function automatic logic [2:0] weekday_of(
        input logic [6:0] yoff,
        input logic [3:0] m,
        input logic [4:0] d
    );
        logic [6:0] yprev;
        logic [4:0] leaps;
        logic [2:0] k;
        logic [7:0] sum;
        yprev = yoff - 7'd1;
        if (m < 4'd3) begin
            leaps = (yoff == 7'd0) ? 5'd0 : 5'(yprev >> 2);
            k     = (yoff == 7'd0) ? 3'd3 : 3'd4;
        end
        else begin
            leaps = 5'(yoff >> 2);
            k     = 3'd2;
        end
        sum = 8'(month_term(m)) + 8'(d) + 8'(yoff) + 8'(leaps) + 8'(k);
        weekday_of = mod7(sum);
    endfunction

endpackage

/* sv/rtc_calendar_with_alarm_top.sv */
// Top level of the RTC calendar with alarm: input word register, update logic, output register.
// Calendar clock with alarm driven by command words: tick, set time, set date,
// set alarm or read. Every accepted word yields exactly one result word with
// the time, date and weekday after the command plus the alarm hit and armed
// flags. The block takes one word per clock while the output side takes results;
// m_axis_tready low stalls it. A word is held in the input register, the time
// and date logic updates the state from it when the word is processed, and the
// result lands in the output register at the same edge as that state update.
// The shared state is read and written in that one update, which sets the
// one-word-per-cycle rate.
module rtc_calendar_with_alarm_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // mode[2:0], in_hours[7:3], in_minutes[13:8], in_seconds[19:14],
    // in_year[26:20], in_month[30:27], in_day[35:31], zero fill[39:36]
    input  logic [rtc_cal_pkg::IN_W-1:0]  s_axis_tdata,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // out_hours[4:0], out_minutes[10:5], out_seconds[16:11], out_year[23:17],
    // out_month[27:24], out_day[32:28], out_weekday[35:33], alarm_hit[36],
    // alarm_armed[37], zero fill[39:38]
    output logic [rtc_cal_pkg::OUT_W-1:0] m_axis_tdata
);
    import rtc_cal_pkg::*;

    logic              in_valid_reg;
    logic [IN_W-1:0]   in_data_reg;
    logic              out_valid_reg;
    logic [OUT_W-1:0]  out_data_reg;

    logic              fire;
    logic              take;
    logic              day_carry;
    mode_t             mode;
    rtc_cal_time_t     time_next;
    rtc_cal_date_t     date_next;
    logic [OUT_W-1:0]  result;

    // process the held word when the output register is free or draining
    assign fire          = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || fire;
    assign take          = s_axis_tvalid && s_axis_tready;
    assign mode          = mode_t'(in_data_reg[2:0]);

    rtc_cal_time u_time (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (fire),
        .mode       (mode),
        .in_hours   (in_data_reg[7:3]),
        .in_minutes (in_data_reg[13:8]),
        .in_seconds (in_data_reg[19:14]),
        .day_carry  (day_carry),
        .time_next  (time_next)
    );

    rtc_cal_date u_date (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .mode      (mode),
        .day_carry (day_carry),
        .in_year   (in_data_reg[26:20]),
        .in_month  (in_data_reg[30:27]),
        .in_day    (in_data_reg[35:31]),
        .date_next (date_next)
    );

    assign result = {2'b00, time_next.armed, time_next.hit, date_next.weekday,
                     date_next.day, date_next.month, date_next.year,
                     time_next.seconds, time_next.minutes, time_next.hours};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
                in_valid_reg <= 1'b1;
            else if (fire)
                in_valid_reg <= 1'b0;
            if (fire)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
            in_data_reg <= s_axis_tdata;
        if (fire)
            out_data_reg <= result;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

/* sv/rtc_cal_time.sv */
// Time-of-day counter, set-time normalization and alarm compare/adjust.
module rtc_cal_time (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   fire,
    input  rtc_cal_pkg::mode_t     mode,
    input  logic [4:0]             in_hours,
    input  logic [5:0]             in_minutes,
    input  logic [5:0]             in_seconds,
    output logic                   day_carry,
    output rtc_cal_pkg::rtc_cal_time_t time_next
);
    import rtc_cal_pkg::*;

    logic [4:0]         hours_reg,   hours_next;
    logic [5:0]         minutes_reg, minutes_next;
    logic [5:0]         seconds_reg, seconds_next;
    logic [SOD_W-1:0]   sod_reg,     sod_next;
    logic [ALARM_W-1:0] alarm_reg,   alarm_next;
    logic               armed_reg,   armed_next;
    logic               hit;

    logic [SOD_W-1:0]   sod_inc;
    logic               wrap;
    logic [SOD_W-1:0]   count_in;
    logic               sec_ovf;
    logic [5:0]         s_norm;
    logic [6:0]         m_sum;
    logic               min_ovf;
    logic [5:0]         m_norm;
    logic [5:0]         h_norm;

    assign sod_inc  = sod_reg + SOD_W'(1);
    assign wrap     = (sod_inc == SOD_W'(DAY_SECONDS));
    assign count_in = hms_count(in_hours, in_minutes, in_seconds);

    // carry seconds and minutes above 59 into the next field
    assign sec_ovf = (in_seconds >= 6'd60);
    assign s_norm  = sec_ovf ? in_seconds - 6'd60 : in_seconds;
    assign m_sum   = {1'b0, in_minutes} + 7'(sec_ovf);
    assign min_ovf = (m_sum >= 7'd60);
    assign m_norm  = 6'(min_ovf ? m_sum - 7'd60 : m_sum);
    assign h_norm  = {1'b0, in_hours} + 6'(min_ovf);

    always_comb
    begin
        hours_next   = hours_reg;
        minutes_next = minutes_reg;
        seconds_next = seconds_reg;
        sod_next     = sod_reg;
        alarm_next   = alarm_reg;
        armed_next   = armed_reg;
        hit          = 1'b0;
        day_carry    = 1'b0;
        if (fire)
        begin
            case (mode)
                MODE_TICK:
                begin
                    hit = armed_reg && ({1'b0, sod_inc} == alarm_reg);
                    if (wrap)
                    begin
                        day_carry    = 1'b1;
                        sod_next     = '0;
                        hours_next   = '0;
                        minutes_next = '0;
                        seconds_next = '0;
                        if (armed_reg && (alarm_reg > ALARM_W'(DAY_SECONDS)))
                            alarm_next = alarm_reg - ALARM_W'(DAY_SECONDS);
                        else
                            armed_next = 1'b0;
                    end
                    else
                    begin
                        sod_next = sod_inc;
                        if (seconds_reg != 6'd59)
                            seconds_next = seconds_reg + 6'd1;
                        else
                        begin
                            seconds_next = '0;
                            if (minutes_reg != 6'd59)
                                minutes_next = minutes_reg + 6'd1;
                            else
                            begin
                                minutes_next = '0;
                                hours_next   = hours_reg + 5'd1;
                            end
                        end
                    end
                end
                MODE_SET_TIME:
                begin
                    if (count_in >= SOD_W'(DAY_SECONDS))
                    begin
                        sod_next     = SOD_W'(DAY_SECONDS - 1);
                        hours_next   = 5'd23;
                        minutes_next = 6'd59;
                        seconds_next = 6'd59;
                    end
                    else
                    begin
                        sod_next     = count_in;
                        hours_next   = h_norm[4:0];
                        minutes_next = m_norm;
                        seconds_next = s_norm;
                    end
                end
                MODE_SET_ALARM:
                begin
                    // alarm before now: push it into tomorrow
                    if (count_in < sod_reg)
                        alarm_next = {1'b0, count_in} + ALARM_W'(DAY_SECONDS);
                    else
                        alarm_next = {1'b0, count_in};
                    armed_next = 1'b1;
                end
                default:
                begin
                    hit = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hours_reg   <= '0;
            minutes_reg <= '0;
            seconds_reg <= '0;
            sod_reg     <= '0;
            alarm_reg   <= '0;
            armed_reg   <= 1'b0;
        end
        else
        begin
            hours_reg   <= hours_next;
            minutes_reg <= minutes_next;
            seconds_reg <= seconds_next;
            sod_reg     <= sod_next;
            alarm_reg   <= alarm_next;
            armed_reg   <= armed_next;
        end
    end

    assign time_next.hours   = hours_next;
    assign time_next.minutes = minutes_next;
    assign time_next.seconds = seconds_next;
    assign time_next.hit     = hit;
    assign time_next.armed   = armed_next;

endmodule

/* sv/rtc_cal_date.sv */
// Calendar date registers: next-day advance, set-date clamping and weekday.
module rtc_cal_date (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       fire,
    input  rtc_cal_pkg::mode_t         mode,
    input  logic                       day_carry,
    input  logic [6:0]                 in_year,
    input  logic [3:0]                 in_month,
    input  logic [4:0]                 in_day,
    output rtc_cal_pkg::rtc_cal_date_t date_next
);
    import rtc_cal_pkg::*;

    logic [6:0] year_reg,  year_next;
    logic [3:0] month_reg, month_next;
    logic [4:0] day_reg,   day_next;
    logic [2:0] wday_reg,  wday_next;

    logic       set_date;
    logic [4:0] cur_len;
    logic [6:0] adv_year;
    logic [3:0] adv_month;
    logic [4:0] adv_day;
    logic [6:0] set_year;
    logic [3:0] set_month;
    logic [4:0] set_len;
    logic [4:0] set_day;
    logic [6:0] cand_year;
    logic [3:0] cand_month;
    logic [4:0] cand_day;
    logic [2:0] cand_wday;

    assign set_date = fire && (mode == MODE_SET_DATE);

    // advance one day
    assign cur_len = month_len(year_reg, month_reg);
    always_comb
    begin
        adv_year  = year_reg;
        adv_month = month_reg;
        adv_day   = day_reg;
        if (day_reg < cur_len)
            adv_day = day_reg + 5'd1;
        else if (month_reg < 4'd12)
        begin
            adv_month = month_reg + 4'd1;
            adv_day   = 5'd1;
        end
        else
        begin
            adv_month = 4'd1;
            adv_day   = 5'd1;
            adv_year  = (year_reg >= 7'(LAST_YEAR)) ? 7'd0 : year_reg + 7'd1;
        end
    end

    // clamp the written date into range
    always_comb
    begin
        set_year  = (in_year >= 7'd100) ? in_year - 7'd100 : in_year;
        set_month = in_month;
        if (set_month == 4'd0)
            set_month = 4'd1;
        if (set_month > 4'd12)
            set_month = 4'd12;
        set_len = month_len(set_year, set_month);
        set_day = in_day;
        if (set_day == 5'd0)
            set_day = 5'd1;
        if (set_day > set_len)
            set_day = set_len;
    end

    assign cand_year  = set_date ? set_year  : adv_year;
    assign cand_month = set_date ? set_month : adv_month;
    assign cand_day   = set_date ? set_day   : adv_day;
    assign cand_wday  = weekday_of(cand_year, cand_month, cand_day);

    always_comb
    begin
        year_next  = year_reg;
        month_next = month_reg;
        day_next   = day_reg;
        wday_next  = wday_reg;
        if (set_date || day_carry)
        begin
            year_next  = cand_year;
            month_next = cand_month;
            day_next   = cand_day;
            wday_next  = cand_wday;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            year_reg  <= '0;
            month_reg <= 4'd1;
            day_reg   <= 5'd1;
            wday_reg  <= 3'd6;
        end
        else
        begin
            year_reg  <= year_next;
            month_reg <= month_next;
            day_reg   <= day_next;
            wday_reg  <= wday_next;
        end
    end

    assign date_next.year    = year_next;
    assign date_next.month   = month_next;
    assign date_next.day     = day_next;
    assign date_next.weekday = wday_next;

endmodule

/* tb/testbench.sv */
// Self-checking testbench for the RTC calendar with alarm: directed table, then random sequences.
`timescale 1ns / 1ps

module testbench;
    import rtc_cal_pkg::*;

    // modes outside the enum that the block must treat as read only
    localparam logic [2:0] MODE_SPARE_5 = 3'd5;
    localparam logic [2:0] MODE_SPARE_6 = 3'd6;
    localparam logic [2:0] MODE_SPARE_7 = 3'd7;

    localparam int unsigned RANDOM_WORDS = 450;
    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned SETTLE       = 8;
    localparam int          N_STEPS      = 26;

    typedef struct packed {
        logic [2:0] mode;
        logic [4:0] hours;
        logic [5:0] minutes;
        logic [5:0] seconds;
        logic [6:0] year;
        logic [3:0] month;
        logic [4:0] day;
    } rtc_cmd_t;

    typedef struct packed {
        logic [4:0] hours;
        logic [5:0] minutes;
        logic [5:0] seconds;
        logic [6:0] year;
        logic [3:0] month;
        logic [4:0] day;
        logic [2:0] weekday;
        logic       hit;
        logic       armed;
    } rtc_view_t;

    typedef struct packed {
        rtc_cmd_t  cmd;
        logic      known;
        rtc_view_t want;
    } step_row_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [IN_W-1:0]   s_axis_tdata = '0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [OUT_W-1:0]  m_axis_tdata;

    rtc_view_t   pending_views[$];
    int unsigned fail_count = 0;
    int unsigned words_sent = 0;
    int unsigned cycle_count = 0;
    bit          no_idle = 1'b0;

    // calendar state as the block should hold it
    int unsigned now_sec;
    int unsigned date_year;
    int unsigned date_month;
    int unsigned date_day;
    int unsigned date_wday;
    int unsigned alarm_at;
    bit          alarm_set;

    // directed steps; rows marked known carry the result to expect literally
    step_row_t steps [N_STEPS] = '{
        '{'{MODE_READ, 0, 0, 0, 0, 0, 0},          1, '{0, 0, 0, 0, 1, 1, 6, 0, 0}},
        '{'{MODE_SPARE_7, 31, 63, 63, 127, 15, 31}, 1, '{0, 0, 0, 0, 1, 1, 6, 0, 0}},
        '{'{MODE_TICK, 0, 0, 0, 0, 0, 0},          1, '{0, 0, 1, 0, 1, 1, 6, 0, 0}},
        '{'{MODE_SET_TIME, 23, 59, 59, 0, 0, 0},   1, '{23, 59, 59, 0, 1, 1, 6, 0, 0}},
        '{'{MODE_SET_ALARM, 0, 0, 0, 0, 0, 0},     1, '{23, 59, 59, 0, 1, 1, 6, 0, 1}},
        '{'{MODE_TICK, 0, 0, 0, 0, 0, 0},          1, '{0, 0, 0, 0, 1, 2, 0, 1, 0}},
        '{'{MODE_SET_TIME, 31, 63, 63, 0, 0, 0},   1, '{23, 59, 59, 0, 1, 2, 0, 0, 0}},
        '{'{MODE_SET_DATE, 0, 0, 0, 127, 15, 31},  0, '0},
        '{'{MODE_SET_DATE, 0, 0, 0, 99, 12, 31},   0, '0},
        '{'{MODE_TICK, 0, 0, 0, 0, 0, 0},          1, '{0, 0, 0, 0, 1, 1, 6, 0, 0}},
        '{'{MODE_SET_DATE, 0, 0, 0, 0, 0, 0},      1, '{0, 0, 0, 0, 1, 1, 6, 0, 0}},
        '{'{MODE_SET_DATE, 0, 0, 0, 4, 2, 31},     0, '0},
        '{'{MODE_SET_DATE, 0, 0, 0, 1, 2, 29},     0, '0},
        '{'{MODE_SET_DATE, 0, 0, 0, 0, 2, 29},     0, '0},
        '{'{MODE_SET_TIME, 23, 59, 58, 0, 0, 0},   0, '0},
        '{'{MODE_SET_ALARM, 24, 0, 0, 0, 0, 0},    0, '0},
        '{'{MODE_TICK, 0, 0, 0, 0, 0, 0},          0, '0},
        '{'{MODE_TICK, 0, 0, 0, 0, 0, 0},          0, '0},
        '{'{MODE_SET_ALARM, 31, 63, 63, 0, 0, 0},  0, '0},
        '{'{MODE_SET_TIME, 23, 59, 59, 0, 0, 0},   0, '0},
        '{'{MODE_TICK, 0, 0, 0, 0, 0, 0},          0, '0},
        '{'{MODE_SET_ALARM, 0, 0, 1, 0, 0, 0},     0, '0},
        '{'{MODE_TICK, 0, 0, 0, 0, 0, 0},          0, '0},
        '{'{MODE_SPARE_5, 10, 20, 30, 50, 6, 15},  0, '0},
        '{'{MODE_SPARE_6, 0, 0, 0, 0, 0, 0},       0, '0},
        '{'{MODE_TICK, 0, 0, 0, 0, 0, 0},          0, '0}
    };

    rtc_calendar_with_alarm_top i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 clk = ~clk;

    function automatic bit is_leap_year(input int unsigned yoff);
        int unsigned y;
        y = 2000 + yoff;
        return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    endfunction

    function automatic int unsigned days_in_month(input int unsigned yoff, input int unsigned m);
        if (m == 2)
            return is_leap_year(yoff) ? 29 : 28;
        if (m == 4 || m == 6 || m == 9 || m == 11)
            return 30;
        return 31;
    endfunction

    function automatic int unsigned weekday_for(
        input int unsigned yoff,
        input int unsigned m,
        input int unsigned d
    );
        int unsigned y;
        int unsigned w;
        y = 2000 + yoff;
        if (m < 3)
            w = (23 * m) / 9 + d + 4 + y + (y - 1) / 4 - (y - 1) / 100 + (y - 1) / 400;
        else
            w = (23 * m) / 9 + d + 4 + y + y / 4 - y / 100 + y / 400 - 2;
        return w % 7;
    endfunction

    function automatic int unsigned hms_to_sec(input rtc_cmd_t c);
        return int'(c.hours) * 3600 + int'(c.minutes) * 60 + int'(c.seconds);
    endfunction

    function automatic void reset_calendar();
        now_sec    = 0;
        date_year  = 0;
        date_month = 1;
        date_day   = 1;
        date_wday  = 6;
        alarm_at   = 0;
        alarm_set  = 1'b0;
    endfunction

    // apply one command to the calendar and return the view after it
    function automatic rtc_view_t step_calendar(input rtc_cmd_t c);
        rtc_view_t   v;
        bit          hit;
        int unsigned a;
        int unsigned m;
        int unsigned d;
        int unsigned len;
        hit = 1'b0;
        case (c.mode)
            MODE_TICK:
            begin
                now_sec++;
                if (alarm_set && now_sec == alarm_at)
                    hit = 1'b1;
                if (now_sec >= DAY_SECONDS)
                begin
                    // shift the alarm into the new day, or drop it if it has passed
                    if (alarm_set && alarm_at > DAY_SECONDS)
                        alarm_at -= DAY_SECONDS;
                    else
                        alarm_set = 1'b0;
                    now_sec = 0;
                    if (date_day < days_in_month(date_year, date_month))
                    begin
                        date_day++;
                    end
                    else if (date_month < 12)
                    begin
                        date_month++;
                        date_day = 1;
                    end
                    else
                    begin
                        date_month = 1;
                        date_day   = 1;
                        date_year  = (date_year >= LAST_YEAR) ? 0 : date_year + 1;
                    end
                    date_wday = weekday_for(date_year, date_month, date_day);
                end
            end
            MODE_SET_TIME:
            begin
                a = hms_to_sec(c);
                now_sec = (a >= DAY_SECONDS) ? DAY_SECONDS - 1 : a;
            end
            MODE_SET_DATE:
            begin
                date_year = int'(c.year) % 100;
                m = int'(c.month);
                if (m == 0)
                    m = 1;
                if (m > 12)
                    m = 12;
                len = days_in_month(date_year, m);
                d = int'(c.day);
                if (d == 0)
                    d = 1;
                if (d > len)
                    d = len;
                date_month = m;
                date_day   = d;
                date_wday  = weekday_for(date_year, m, d);
            end
            MODE_SET_ALARM:
            begin
                a = hms_to_sec(c);
                if (a < now_sec)
                    a += DAY_SECONDS;
                alarm_at  = a % (1 << ALARM_W);
                alarm_set = 1'b1;
            end
            default: ;
        endcase
        v.hours   = 5'(now_sec / 3600);
        v.minutes = 6'((now_sec % 3600) / 60);
        v.seconds = 6'(now_sec % 60);
        v.year    = 7'(date_year);
        v.month   = 4'(date_month);
        v.day     = 5'(date_day);
        v.weekday = 3'(date_wday);
        v.hit     = hit;
        v.armed   = alarm_set;
        return v;
    endfunction

    function automatic rtc_cmd_t mk_cmd(
        input logic [2:0]  mode,
        input int unsigned h,
        input int unsigned mi,
        input int unsigned s,
        input int unsigned y,
        input int unsigned mo,
        input int unsigned d
    );
        rtc_cmd_t c;
        c.mode    = mode;
        c.hours   = 5'(h);
        c.minutes = 6'(mi);
        c.seconds = 6'(s);
        c.year    = 7'(y);
        c.month   = 4'(mo);
        c.day     = 5'(d);
        return c;
    endfunction

    function automatic int unsigned pick_gap();
        return no_idle ? 0 : $urandom_range(0, 15);
    endfunction

    // called at a falling edge; returns at the falling edge after the word is taken
    task automatic put_word(
        input rtc_cmd_t  c,
        input bit        known = 1'b0,
        input rtc_view_t want = '0
    );
        int unsigned idle;
        rtc_view_t   predicted;
        idle = pick_gap();
        if (idle != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (idle) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0, c.day, c.month, c.year, c.seconds, c.minutes, c.hours, c.mode};
        do
            @(posedge clk);
        while (!s_axis_tready);
        predicted = step_calendar(c);
        pending_views.push_back(known ? want : predicted);
        words_sent++;
        @(negedge clk);
    endtask

    // hold off the sender until every expected word is back
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (pending_views.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic compare_field(input string name, input int unsigned want, input int unsigned got);
        if (want != got)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk)
    begin : result_check
        rtc_view_t got;
        rtc_view_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.hours   = m_axis_tdata[4:0];
            got.minutes = m_axis_tdata[10:5];
            got.seconds = m_axis_tdata[16:11];
            got.year    = m_axis_tdata[23:17];
            got.month   = m_axis_tdata[27:24];
            got.day     = m_axis_tdata[32:28];
            got.weekday = m_axis_tdata[35:33];
            got.hit     = m_axis_tdata[36];
            got.armed   = m_axis_tdata[37];
            if (pending_views.size() == 0)
            begin
                $error("result word with no expectation pending");
                fail_count++;
            end
            else
            begin
                want = pending_views.pop_front();
                compare_field("out_hours", int'(want.hours), int'(got.hours));
                compare_field("out_minutes", int'(want.minutes), int'(got.minutes));
                compare_field("out_seconds", int'(want.seconds), int'(got.seconds));
                compare_field("out_year", int'(want.year), int'(got.year));
                compare_field("out_month", int'(want.month), int'(got.month));
                compare_field("out_day", int'(want.day), int'(got.day));
                compare_field("out_weekday", int'(want.weekday), int'(got.weekday));
                compare_field("alarm_hit", int'(want.hit), int'(got.hit));
                compare_field("alarm_armed", int'(want.armed), int'(got.armed));
                compare_field("zero fill", 0, int'(m_axis_tdata[OUT_W-1:38]));
            end
        end
    end

    // result side: stall a random number of cycles before taking each word
    initial
    begin : result_sink
        int unsigned stall;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = pick_gap();
            if (stall != 0)
            begin
                @(negedge clk);
                m_axis_tready <= 1'b0;
                repeat (stall - 1) @(negedge clk);
            end
            @(negedge clk);
            m_axis_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_axis_tvalid);
        end
    end

    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin : stimulus
        int          i;
        int unsigned sel;
        int unsigned t;
        int unsigned k;
        int unsigned n;
        int unsigned y;
        int unsigned mo;
        reset_calendar();
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;

        for (i = 0; i < N_STEPS; i++)
            put_word(steps[i].cmd, steps[i].known, steps[i].want);
        drain_results();

        while (words_sent < N_STEPS + RANDOM_WORDS)
        begin
            if ($urandom_range(0, 15) == 0)
                no_idle = ~no_idle;
            sel = $urandom_range(0, 11);
            if (sel <= 1)
            begin
                // noise: any mode, every field at full width
                put_word(mk_cmd(3'($urandom_range(MODE_TICK, MODE_SPARE_7)),
                                $urandom_range(0, 31),
                                $urandom_range(0, 63), $urandom_range(0, 63),
                                $urandom_range(0, 127), $urandom_range(0, 15),
                                $urandom_range(0, 31)));
            end
            else if (sel == 2)
            begin
                put_word(mk_cmd(MODE_SET_DATE, 0, 0, 0, $urandom_range(0, 99),
                                $urandom_range(1, 12), $urandom_range(1, 31)));
            end
            else if (sel <= 6)
            begin
                // run across midnight, often from a month end, often with an alarm near it
                if ($urandom_range(0, 2) != 0)
                begin
                    if ($urandom_range(0, 5) == 0)
                    begin
                        y  = LAST_YEAR;
                        mo = 12;
                    end
                    else
                    begin
                        y  = $urandom_range(0, 99);
                        mo = $urandom_range(1, 12);
                    end
                    put_word(mk_cmd(MODE_SET_DATE, 0, 0, 0, y, mo, $urandom_range(28, 31)));
                end
                put_word(mk_cmd(MODE_SET_TIME, 23, 59, $urandom_range(45, 59), 0, 0, 0));
                case ($urandom_range(0, 4))
                    0: put_word(mk_cmd(MODE_SET_ALARM, 0, 0, $urandom_range(0, 5), 0, 0, 0));
                    1: put_word(mk_cmd(MODE_SET_ALARM, 24, 0, 0, 0, 0, 0));
                    2: put_word(mk_cmd(MODE_SET_ALARM, 23, 59, $urandom_range(50, 59), 0, 0, 0));
                    3: put_word(mk_cmd(MODE_SET_ALARM, $urandom_range(0, 31), $urandom_range(0, 63),
                                       $urandom_range(0, 63), 0, 0, 0));
                    default: ;
                endcase
                n = $urandom_range(1, 15);
                repeat (n) put_word(mk_cmd(MODE_TICK, 0, 0, 0, 0, 0, 0));
            end
            else if (sel <= 8)
            begin
                // alarm a few seconds ahead inside the day
                t = $urandom_range(0, DAY_SECONDS - 20);
                k = $urandom_range(0, 8);
                put_word(mk_cmd(MODE_SET_TIME, t / 3600, (t % 3600) / 60, t % 60, 0, 0, 0));
                t += k;
                put_word(mk_cmd(MODE_SET_ALARM, t / 3600, (t % 3600) / 60, t % 60, 0, 0, 0));
                n = $urandom_range(1, 12);
                repeat (n) put_word(mk_cmd(MODE_TICK, 0, 0, 0, 0, 0, 0));
            end
            else if (sel == 9)
            begin
                put_word(mk_cmd(3'(MODE_READ + $urandom_range(0, 3)), $urandom_range(0, 31),
                                $urandom_range(0, 63), $urandom_range(0, 63),
                                $urandom_range(0, 127), $urandom_range(0, 15),
                                $urandom_range(0, 31)));
            end
            else if (sel == 10)
            begin
                put_word(mk_cmd(MODE_TICK, 0, 0, 0, 0, 0, 0));
            end
            else
            begin
                drain_results();
            end
        end

        drain_results();
        repeat (SETTLE) @(posedge clk);
        if (pending_views.size() != 0)
        begin
            $error("%0d expected words never arrived", pending_views.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

/* filelist.f */
sv/rtc_cal_pkg.sv
sv/rtc_cal_time.sv
sv/rtc_cal_date.sv
sv/rtc_calendar_with_alarm_top.sv
tb/testbench.sv
